>>> src/lpht_pkg.sv
// Shared constants and types for the linear-probe hash table.
// Used by linear_probe_hash_table, lpht_checker and testbench; depends on nothing.
package lpht_pkg;

  localparam int TABLE_SLOTS_DEF   = 64;
  localparam int MAX_KEY_CHARS_DEF = 8;

  localparam int KEY_W    = 64;
  localparam int KLEN_W   = 4;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_OUT_W = 6;
  localparam int HASH_W   = 30;

  localparam logic [HASH_W-1:0] HASH_PRIME = 30'd1000000007;
  localparam logic [31:0]       FIB_MULT   = 32'd2654435769;
  localparam logic [7:0]        LOWER_BASE = 8'd97;
  localparam logic [7:0]        UPPER_BASE = 8'd65;

  // Base 33 = 2^5 + 1: five doublings, one add of the old hash.
  localparam int HASH_DOUBLINGS = 5;

  localparam logic [1:0] OP_PUT    = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_KEY = 2'd2;

  typedef struct packed {
    logic              used;
    logic              tomb;
    logic [KLEN_W-1:0] klen;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } entry_t;

endpackage

>>> src/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/linear_probe_hash_table.sv
// Top level of the linear-probe hash table: sequencer, shared modular adder,
// shared multiplier and one slot RAM. Depends on lpht_pkg and lpht_ram.
//
//  channel | ports               | beat contents (low bit up)
//  --------+---------------------+------------------------------------------
//  input   | in_tvalid/in_tready | tuser: operation; tdata: key_chars,
//          |                     |   key_length, value_in, zero pad
//  result  | out_tvalid/tready   | tuser: status; tdata: value_out, slot, pad
//
// Per beat: accept, hash each key character (last first), a Fibonacci
// multiply and a scale multiply, read the home slot, walk the probed slots
// (1..TABLE_SLOTS), then hand off the result; key length and the probe walk
// set the time taken. The block takes one beat at a time.
// After reset a clearing pass writes every slot with in_tready low.
// A stalled result waits in the output register; the next beat may be
// accepted while it waits, and its own result holds until taken.
module linear_probe_hash_table #(
  parameter int TABLE_SLOTS   = lpht_pkg::TABLE_SLOTS_DEF,
  parameter int MAX_KEY_CHARS = lpht_pkg::MAX_KEY_CHARS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // operation
  input  logic [103:0] in_tdata,   // key_chars[63:0], key_length[67:64],
                                   // value_in[99:68], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [1:0]   out_tuser,  // status
  output logic [39:0]  out_tdata   // value_out[31:0], slot[37:32], zero pad
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W  = SLOT_W + 1;
  localparam int ENT_W  = $bits(lpht_pkg::entry_t);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(TABLE_SLOTS - 1);
  localparam logic [lpht_pkg::KLEN_W-1:0] MAXK =
    lpht_pkg::KLEN_W'(MAX_KEY_CHARS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_HASH = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_RDH  = 3'd5;
  localparam logic [2:0] S_EVAL = 3'd6;
  localparam logic [2:0] S_RESP = 3'd7;

  logic [2:0] state_r, state_nxt;

  // Latched request
  logic [1:0]                      op_r, op_nxt;
  logic [lpht_pkg::KEY_W-1:0]      key_r, key_nxt;
  logic [lpht_pkg::KLEN_W-1:0]     len_r, len_nxt;
  logic [lpht_pkg::VAL_W-1:0]      val_r, val_nxt;

  // Hash sequencer
  logic [2:0]                      ci_r, ci_nxt;
  logic [2:0]                      sub_r, sub_nxt;
  logic [lpht_pkg::HASH_W-1:0]     h_r, h_nxt;
  logic [lpht_pkg::HASH_W-1:0]     x_r, x_nxt;
  logic [31:0]                     frac_r, frac_nxt;

  // Probe
  logic [SLOT_W-1:0]               s_r, s_nxt;
  logic [CNT_W-1:0]                n_r, n_nxt;

  // Pending and output result
  logic [lpht_pkg::STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [lpht_pkg::VAL_W-1:0]      res_value_r, res_value_nxt;
  logic [lpht_pkg::SLOT_OUT_W-1:0] res_slot_r, res_slot_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [lpht_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [lpht_pkg::VAL_W-1:0]      out_value_r, out_value_nxt;
  logic [lpht_pkg::SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;

  // Input unpack and key check
  logic [lpht_pkg::KEY_W-1:0]      in_key_raw;
  logic [lpht_pkg::KLEN_W-1:0]     in_len_raw, in_len_sat;
  logic [lpht_pkg::KEY_W-1:0]      in_key_mask;
  logic                            in_bad;
  logic                            in_fire;

  // Shared units
  logic [lpht_pkg::HASH_W-1:0]     add_a, add_b, add_r;
  logic [lpht_pkg::HASH_W:0]       add_sum;
  logic [31:0]                     mul_a, mul_b;
  logic [63:0]                     mul_p;
  logic [7:0]                      ch_byte, ch_ofs;

  // RAM port
  logic                            ram_we;
  logic [SLOT_W-1:0]               ram_waddr, ram_raddr;
  lpht_pkg::entry_t                ram_wdata, ram_rdata;
  logic [ENT_W-1:0]                ram_rdata_raw;
  logic [SLOT_W-1:0]               s_inc;
  logic                            key_hit;

  assign in_key_raw = in_tdata[63:0];
  assign in_len_raw = in_tdata[67:64];
  assign in_fire    = in_tvalid & in_tready;
  assign in_tready  = (state_r == S_IDLE);

  // Saturate the length, mask unused bytes, flag a zero length or any used byte below 'A'.
  always_comb begin
    in_len_sat  = (in_len_raw > MAXK) ? MAXK : in_len_raw;
    in_bad      = (in_len_sat == '0);
    in_key_mask = '0;
    for (int i = 0; i < 8; i++) begin
      if (lpht_pkg::KLEN_W'(i) < in_len_sat) begin
        in_key_mask[i*8 +: 8] = in_key_raw[i*8 +: 8];
        if (in_key_raw[i*8 +: 8] < lpht_pkg::UPPER_BASE) begin
          in_bad = 1'b1;
        end
      end
    end
  end

  // Letter offset of the current character.
  assign ch_byte = key_r[ci_r*8 +: 8];
  assign ch_ofs  = (ch_byte >= lpht_pkg::LOWER_BASE) ? ch_byte - lpht_pkg::LOWER_BASE
                                                     : ch_byte - lpht_pkg::UPPER_BASE;

  // Shared modular adder: both operands below the prime.
  always_comb begin
    add_a = x_r;
    add_b = x_r;
    if (sub_r == 3'(lpht_pkg::HASH_DOUBLINGS)) begin
      add_b = h_r;
    end else if (sub_r > 3'(lpht_pkg::HASH_DOUBLINGS)) begin
      add_b = lpht_pkg::HASH_W'(ch_ofs);
    end else if (sub_r == 3'd0) begin
      add_a = h_r;
      add_b = h_r;
    end
  end
  assign add_sum = {1'b0, add_a} + {1'b0, add_b};
  assign add_r   = (add_sum >= {1'b0, lpht_pkg::HASH_PRIME})
                 ? lpht_pkg::HASH_W'(add_sum - {1'b0, lpht_pkg::HASH_PRIME})
                 : add_sum[lpht_pkg::HASH_W-1:0];

  // Shared multiplier: Fibonacci scramble, then scale to the slot count.
  assign mul_a = (state_r == S_MUL2) ? frac_r : {2'b00, h_r};
  assign mul_b = (state_r == S_MUL2) ? 32'(TABLE_SLOTS) : lpht_pkg::FIB_MULT;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  assign s_inc     = (s_r == LAST_SLOT) ? '0 : s_r + 1'b1;
  assign ram_raddr = (state_r == S_EVAL) ? s_inc : s_r;
  assign ram_waddr = s_r;
  assign ram_rdata = lpht_pkg::entry_t'(ram_rdata_raw);
  assign key_hit   = ram_rdata.used && !ram_rdata.tomb &&
                     (ram_rdata.klen == len_r) && (ram_rdata.key == key_r);

  lpht_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    len_nxt        = len_r;
    val_nxt        = val_r;
    ci_nxt         = ci_r;
    sub_nxt        = sub_r;
    h_nxt          = h_r;
    x_nxt          = x_r;
    frac_nxt       = frac_r;
    s_nxt          = s_r;
    n_nxt          = n_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_slot_nxt   = res_slot_r;
    ram_we         = 1'b0;
    ram_wdata      = '0;

    // Drain the output register independently of the sequencer.
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_slot_nxt   = out_slot_r;

    case (state_r)
      S_CLR: begin
        // Zero one slot per cycle: used and tombstone flags drop.
        ram_we = 1'b1;
        s_nxt  = s_inc;
        if (s_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          op_nxt         = in_tuser;
          key_nxt        = in_key_mask;
          len_nxt        = in_len_sat;
          val_nxt        = in_tdata[99:68];
          h_nxt          = '0;
          sub_nxt        = '0;
          ci_nxt         = 3'(in_len_sat - 1'b1);
          res_value_nxt  = '0;
          res_slot_nxt   = '0;
          res_status_nxt = lpht_pkg::ST_MISS;
          if (in_bad) begin
            res_status_nxt = lpht_pkg::ST_BAD_KEY;
            state_nxt      = S_RESP;
          end else if (in_tuser == lpht_pkg::OP_PUT || in_tuser == lpht_pkg::OP_GET ||
                       in_tuser == lpht_pkg::OP_REMOVE) begin
            state_nxt = S_HASH;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_HASH: begin
        // Horner step, last character first: h = 33*h + c mod prime.
        if (sub_r == 3'(lpht_pkg::HASH_DOUBLINGS + 1)) begin
          h_nxt   = add_r;
          sub_nxt = '0;
          if (ci_r == '0) begin
            state_nxt = S_MUL1;
          end else begin
            ci_nxt = ci_r - 1'b1;
          end
        end else begin
          x_nxt   = add_r;
          sub_nxt = sub_r + 1'b1;
        end
      end
      S_MUL1: begin
        frac_nxt  = mul_p[31:0];
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        s_nxt     = mul_p[32 +: SLOT_W];
        n_nxt     = '0;
        state_nxt = S_RDH;
      end
      S_RDH: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        // Evaluate slot s_r; the read of the next slot is already issued.
        if (op_r == lpht_pkg::OP_PUT) begin
          if (!ram_rdata.used) begin
            ram_we          = 1'b1;
            ram_wdata.used  = 1'b1;
            ram_wdata.tomb  = 1'b0;
            ram_wdata.klen  = len_r;
            ram_wdata.key   = key_r;
            ram_wdata.value = val_r;
            res_status_nxt  = lpht_pkg::ST_OK;
            res_slot_nxt    = lpht_pkg::SLOT_OUT_W'(s_r);
            state_nxt       = S_RESP;
          end
        end else if (!ram_rdata.used) begin
          state_nxt = S_RESP;
        end else if (key_hit) begin
          res_status_nxt = lpht_pkg::ST_OK;
          res_slot_nxt   = lpht_pkg::SLOT_OUT_W'(s_r);
          if (op_r == lpht_pkg::OP_GET) begin
            res_value_nxt = ram_rdata.value;
          end else begin
            ram_we         = 1'b1;
            ram_wdata      = ram_rdata;
            ram_wdata.tomb = 1'b1;
          end
          state_nxt = S_RESP;
        end
        if (state_nxt == S_EVAL) begin
          if (n_r == LAST_CNT) begin
            state_nxt = S_RESP;
          end else begin
            s_nxt = s_inc;
            n_nxt = n_r + 1'b1;
          end
        end
      end
      S_RESP: begin
        // Hand off once the output register is free or being taken.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_slot_nxt   = res_slot_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      s_r         <= '0;
      n_r         <= '0;
      ci_r        <= '0;
      sub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s_r         <= s_nxt;
      n_r         <= n_nxt;
      ci_r        <= ci_nxt;
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    len_r        <= len_nxt;
    val_r        <= val_nxt;
    h_r          <= h_nxt;
    x_r          <= x_nxt;
    frac_r       <= frac_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_slot_r, out_value_r};

  // Slot writes happen only in the clearing pass or when a probe resolves.
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLR || state_r == S_EVAL))
    else $error("slot RAM written outside clear or probe");

  // The probe walk never visits more slots than the table holds.
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> (n_r <= LAST_CNT))
    else $error("probe count past table size");

  // An accepted beat always leads into hashing or straight to the result.
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_HASH || state_r == S_RESP))
    else $error("accepted beat did not start work");

  // A put that succeeds has just written its slot.
  a_put_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && op_r == lpht_pkg::OP_PUT && state_nxt == S_RESP &&
     res_status_nxt == lpht_pkg::ST_OK) |-> ram_we)
    else $error("successful put without slot write");

endmodule

>>> test/lpht_checker.sv
// Result checker for the linear-probe hash table: watches both stream channels,
// keeps its own copy of the table and compares every result beat.
// Depends on lpht_pkg for field widths and operation/status codes.
module lpht_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [1:0]   in_tuser,
  input  logic [103:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [1:0]   out_tuser,
  input  logic [39:0]  out_tdata,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [5:0]  slot;
  } lookup_t;

  logic [63:0] tbl_key [64];
  logic [3:0]  tbl_len [64];
  logic [31:0] tbl_val [64];
  logic        tbl_used [64];
  logic        tbl_tomb [64];
  lookup_t     answers [$];

  function automatic logic [5:0] home_of(logic [63:0] key, int len);
    longint unsigned h;
    longint unsigned c;
    longint unsigned frac;
    h = 0;
    for (int i = len - 1; i >= 0; i--) begin
      c = key[8*i +: 8];
      c = (c >= lpht_pkg::LOWER_BASE) ? c - lpht_pkg::LOWER_BASE
                                      : c - lpht_pkg::UPPER_BASE;
      // offsets behave as 32-bit unsigned values
      c = c & 64'hFFFF_FFFF;
      h = (h * 33 + c) % 1000000007;
    end
    frac = (h * 64'd2654435769) & 64'hFFFF_FFFF;
    return frac[31:26];
  endfunction

  function automatic lookup_t apply_op(logic [1:0] op, logic [63:0] raw, logic [3:0] rlen,
                                       logic [31:0] val);
    lookup_t r;
    int len;
    logic [63:0] key;
    logic bad;
    int s;
    r = '{status: lpht_pkg::ST_MISS, value: '0, slot: '0};
    len = (rlen > 8) ? 8 : rlen;
    bad = (len == 0);
    key = '0;
    for (int i = 0; i < len; i++) begin
      if (raw[8*i +: 8] < lpht_pkg::UPPER_BASE) bad = 1'b1;
      key[8*i +: 8] = raw[8*i +: 8];
    end
    if (bad) begin
      r.status = lpht_pkg::ST_BAD_KEY;
    end else if (op == lpht_pkg::OP_PUT) begin
      s = home_of(key, len);
      for (int n = 0; n < 64; n++) begin
        if (!tbl_used[s]) begin
          tbl_key[s] = key; tbl_len[s] = 4'(len); tbl_val[s] = val;
          tbl_used[s] = 1'b1; tbl_tomb[s] = 1'b0;
          r.status = lpht_pkg::ST_OK; r.slot = 6'(s);
          break;
        end
        s = (s + 1) % 64;
      end
    end else if (op == lpht_pkg::OP_GET || op == lpht_pkg::OP_REMOVE) begin
      s = home_of(key, len);
      for (int n = 0; n < 64; n++) begin
        if (!tbl_used[s]) break;
        if (!tbl_tomb[s] && tbl_len[s] == len && tbl_key[s] == key) begin
          r.status = lpht_pkg::ST_OK; r.slot = 6'(s);
          if (op == lpht_pkg::OP_GET) r.value = tbl_val[s];
          else tbl_tomb[s] = 1'b1;
          break;
        end
        s = (s + 1) % 64;
      end
    end
    return r;
  endfunction

  assign pending = answers.size();

  always @(posedge clk) begin
    lookup_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      answers.delete();
      for (int i = 0; i < 64; i++) begin
        tbl_used[i] = 1'b0;
        tbl_tomb[i] = 1'b0;
      end
    end else begin
      if (out_tvalid && out_tready) begin
        if (answers.size() == 0) begin
          $error("unexpected result beat status=%0d", out_tuser);
          errs++;
        end else begin
          want = answers.pop_front();
          if (out_tuser !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_tuser);
            errs++;
          end
          if (out_tdata[31:0] !== want.value) begin
            $error("value_out expected %h actual %h", want.value, out_tdata[31:0]);
            errs++;
          end
          if (out_tdata[37:32] !== want.slot) begin
            $error("slot expected %0d actual %0d", want.slot, out_tdata[37:32]);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      if (in_tvalid && in_tready)
        answers.push_back(apply_op(in_tuser, in_tdata[63:0], in_tdata[67:64],
                                   in_tdata[99:68]));
    end
  end
endmodule

>>> test/testbench.sv
// Top of the hash table testbench: clock, reset, stimulus and verdict.
// Depends on lpht_pkg, linear_probe_hash_table and lpht_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [1:0]   in_tuser = '0;
  logic [103:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [1:0]   out_tuser;
  logic [39:0]  out_tdata;
  int           fail_count;
  int           pending;

  // idle odds in percent for the sender and the receiver
  int send_idle = 0;
  int recv_idle = 0;

  // small key pool so gets and removes hit stored keys often
  logic [63:0] pool_key [16];
  logic [3:0]  pool_len [16];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  linear_probe_hash_table u_top (.*);

  lpht_checker u_chk (.*);

  // receiver: stall at random with the current odds
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Present one beat and hold it until accepted; valid stays high afterwards
  // and drops only when the next call idles or drain runs.
  task automatic send_beat(logic [1:0] op, logic [63:0] key, logic [3:0] len,
                           logic [31:0] val);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'd0, val, len, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_letters(int len);
    logic [63:0] k;
    k = {$urandom, $urandom};
    for (int i = 0; i < len; i++)
      k[8*i +: 8] = ($urandom_range(1)) ? 8'(65 + $urandom_range(25))
                                         : 8'(97 + $urandom_range(25));
    return k;
  endfunction

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    int p;
    logic [1:0] op;
    logic [63:0] k;
    for (int n = 0; n < count; n++) begin
      p = $urandom_range(15);
      case ($urandom_range(9))
        0: send_beat(lpht_pkg::OP_UNUSED, pool_key[p], pool_len[p], $urandom);
        1: send_beat(2'($urandom_range(2)), {$urandom, $urandom},
                     4'($urandom_range(15)), $urandom);
        2: begin
          k = rand_letters(8);
          send_beat(2'($urandom_range(2)), k, 4'($urandom_range(9, 15)), $urandom);
        end
        default: begin
          op = 2'($urandom_range(2));
          // keep the table filling slowly: fewer puts than lookups
          if (op == lpht_pkg::OP_PUT && $urandom_range(2) != 0) op = lpht_pkg::OP_GET;
          send_beat(op, pool_key[p], pool_len[p], $urandom);
        end
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) begin
      pool_len[i] = (i < 12) ? 4'($urandom_range(1, 3)) : 4'($urandom_range(4, 8));
      pool_key[i] = rand_letters(pool_len[i]);
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every operation, bad keys, length zero and above 8
    send_beat(lpht_pkg::OP_PUT, 64'h4141_4141_4141_4141, 4'd8, 32'hFFFF_FFFF);
    send_beat(lpht_pkg::OP_GET, 64'h4141_4141_4141_4141, 4'd8, 32'd0);
    send_beat(lpht_pkg::OP_PUT, 64'h7A7A_7A7A_7A7A_7A7A, 4'd15, 32'd0);
    send_beat(lpht_pkg::OP_GET, 64'hFF7A_7A7A_7A7A_7A7A, 4'd8, 32'd0);
    send_beat(lpht_pkg::OP_PUT, 64'hFFFF_FFFF_FFFF_FF41, 4'd1, 32'h1234_5678);
    send_beat(lpht_pkg::OP_PUT, 64'h0000_0000_0000_0041, 4'd1, 32'h8765_4321);
    send_beat(lpht_pkg::OP_GET, 64'h0000_0000_0000_0041, 4'd1, 32'd0);
    send_beat(lpht_pkg::OP_REMOVE, 64'h0000_0000_0000_0041, 4'd1, 32'd0);
    send_beat(lpht_pkg::OP_GET, 64'h0000_0000_0000_0041, 4'd1, 32'd0);
    send_beat(lpht_pkg::OP_REMOVE, 64'h0000_0000_0000_0041, 4'd1, 32'd0);
    send_beat(lpht_pkg::OP_REMOVE, 64'h0000_0000_0000_0061, 4'd1, 32'd0);
    send_beat(lpht_pkg::OP_GET, 64'h0000_0000_0000_0040, 4'd1, 32'd0);
    send_beat(lpht_pkg::OP_PUT, 64'h0041_4141_0041_4141, 4'd8, 32'd5);
    send_beat(lpht_pkg::OP_GET, 64'h4141_4141, 4'd0, 32'd0);
    send_beat(lpht_pkg::OP_UNUSED, 64'h4141_4141_4141_4141, 4'd8, 32'd0);
    send_beat(lpht_pkg::OP_GET, 64'h0000_0000_0000_4242, 4'd2, 32'd0);

    // fill the table past full to reach the no-free-slot case
    for (int i = 0; i < 70; i++)
      send_beat(lpht_pkg::OP_PUT, 64'h5858_5858, 4'd4, 32'(i));
    send_beat(lpht_pkg::OP_GET, 64'h5A5A_5A5A, 4'd4, 32'd0);
    drain();
    // table stays full from here on: removes only mark tombstones and reset is
    // not repeated, so puts find no free slot
    send_idle = 0;  recv_idle = 0;  random_phase(230);
    drain();
    send_idle = 46; recv_idle = 0;  random_phase(230);
    send_idle = 0;  recv_idle = 46; random_phase(230);
    drain();
    send_idle = 27; recv_idle = 27; random_phase(230);
    drain();

    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
